/* hdl/fsk_phase_discriminator_assert.svh */
// Assertion helpers for the FSK phase discriminator checker.
`ifndef FSK_PHASE_DISCRIMINATOR_ASSERT_SVH
`define FSK_PHASE_DISCRIMINATOR_ASSERT_SVH

// Checked while out of reset.
`define FPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define FPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hdl/fpd_pkg.sv */
`default_nettype none
package fpd_pkg;

    localparam int MAX_TAPS     = 129;
    localparam int CORDIC_STEPS = 16;

    localparam int ADDR_W = $clog2(MAX_TAPS);
    localparam int CNT_W0 = $clog2(MAX_TAPS + 2);
    localparam int CNT_W  = (CNT_W0 > 5) ? CNT_W0 : 5;
    localparam int ACC_W  = 34 + $clog2(MAX_TAPS);
    localparam int CW     = 36;

    typedef enum logic [1:0] {
        ACT_SAMPLE  = 2'd0,
        ACT_LOAD_IQ = 2'd1,
        ACT_LOAD_PH = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    localparam logic [0:0] REG_IQ_TAPS = 1'b0;
    localparam logic [0:0] REG_PH_TAPS = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC_IQ,
        ST_FIN_IQ,
        ST_CPLX_MUL,
        ST_CPLX_ADD,
        ST_CORD_INIT,
        ST_CORD_RUN,
        ST_RAW_FIN,
        ST_MAC_PH,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic             coef_wr_iq;
        logic             coef_wr_ph;
        logic             push;
        logic             acc_clr;
        logic             mac_issue;
        logic             mac_sel;
        logic [CNT_W-1:0] k;
        logic             iq_fin;
        logic             cplx_mul;
        logic             cplx_add;
        logic             cord_init;
        logic             cord_step;
        logic             raw_fin;
        logic             out_load;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

    function automatic logic [31:0] atan_lut(input logic [4:0] k);
        logic [31:0] r;
        unique case (k)
            5'd0:    r = 32'd536870912;
            5'd1:    r = 32'd316933406;
            5'd2:    r = 32'd167458907;
            5'd3:    r = 32'd85004756;
            5'd4:    r = 32'd42667331;
            5'd5:    r = 32'd21354465;
            5'd6:    r = 32'd10679838;
            5'd7:    r = 32'd5340245;
            5'd8:    r = 32'd2670163;
            5'd9:    r = 32'd1335087;
            5'd10:   r = 32'd667544;
            5'd11:   r = 32'd333772;
            5'd12:   r = 32'd166886;
            5'd13:   r = 32'd83443;
            5'd14:   r = 32'd41722;
            5'd15:   r = 32'd20861;
            5'd16:   r = 32'd10430;
            5'd17:   r = 32'd5215;
            5'd18:   r = 32'd2608;
            5'd19:   r = 32'd1304;
            5'd20:   r = 32'd652;
            5'd21:   r = 32'd326;
            5'd22:   r = 32'd163;
            5'd23:   r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // (acc + 2^16) >>> 17, clamped to 16 bits
    function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] s;
        logic signed [15:0]      r;
        t = acc + ACC_W'(65536);
        s = t >>> 17;
        if (s > ACC_W'(32767)) begin
            r = 16'sh7FFF;
        end else if (s < -ACC_W'(32768)) begin
            r = -16'sh8000;
        end else begin
            r = s[15:0];
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] clamp_taps(input logic [7:0] t);
        logic [CNT_W-1:0] r;
        if (t == 8'd0) begin
            r = CNT_W'(1);
        end else if (int'(t) > MAX_TAPS) begin
            r = CNT_W'(MAX_TAPS);
        end else begin
            r = CNT_W'(t);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hdl/fpd_ctrl.sv */
`default_nettype none
module fpd_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire  [1:0]           i_action,
    input  wire                  i_cfg_we,
    input  wire  [0:0]           i_cfg_idx,
    input  wire  [7:0]           i_cfg_data,
    output fpd_pkg::t_cmd        o_cmd,
    input  fpd_pkg::t_sts        i_sts
);

    fpd_pkg::t_state             r_state, n_state;
    logic [fpd_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [7:0]                  r_iq_taps;
    logic [7:0]                  r_ph_taps;
    logic [fpd_pkg::CNT_W-1:0]   iq_taps;
    logic [fpd_pkg::CNT_W-1:0]   ph_taps;
    logic                        accept;

    assign iq_taps = fpd_pkg::clamp_taps(r_iq_taps);
    assign ph_taps = fpd_pkg::clamp_taps(r_ph_taps);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iq_taps <= 8'd65;
            r_ph_taps <= 8'd129;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fpd_pkg::REG_IQ_TAPS: r_iq_taps <= i_cfg_data;
                fpd_pkg::REG_PH_TAPS: r_ph_taps <= i_cfg_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpd_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        o_cmd   = '0;
        o_cmd.k = r_cnt;
        n_state = r_state;
        n_cnt   = r_cnt;
        o_ready = (r_state == fpd_pkg::ST_IDLE);
        accept  = i_valid && o_ready;
        unique case (r_state)
            fpd_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (fpd_pkg::t_action'(i_action))
                        fpd_pkg::ACT_SAMPLE: begin
                            o_cmd.push    = 1'b1;
                            o_cmd.acc_clr = 1'b1;
                            n_cnt         = '0;
                            n_state       = fpd_pkg::ST_MAC_IQ;
                        end
                        fpd_pkg::ACT_LOAD_IQ: o_cmd.coef_wr_iq = 1'b1;
                        fpd_pkg::ACT_LOAD_PH: o_cmd.coef_wr_ph = 1'b1;
                        fpd_pkg::ACT_NONE:    ;
                        default:              ;
                    endcase
                end
            end
            fpd_pkg::ST_MAC_IQ: begin
                // the counts past the last tap drain the read and multiply stages
                o_cmd.mac_issue = (r_cnt < iq_taps);
                if (r_cnt == iq_taps + fpd_pkg::CNT_W'(1)) begin
                    n_state = fpd_pkg::ST_FIN_IQ;
                end else begin
                    n_cnt = r_cnt + fpd_pkg::CNT_W'(1);
                end
            end
            fpd_pkg::ST_FIN_IQ: begin
                o_cmd.iq_fin = 1'b1;
                n_state      = fpd_pkg::ST_CPLX_MUL;
            end
            fpd_pkg::ST_CPLX_MUL: begin
                o_cmd.cplx_mul = 1'b1;
                n_state        = fpd_pkg::ST_CPLX_ADD;
            end
            fpd_pkg::ST_CPLX_ADD: begin
                o_cmd.cplx_add = 1'b1;
                n_state        = fpd_pkg::ST_CORD_INIT;
            end
            fpd_pkg::ST_CORD_INIT: begin
                o_cmd.cord_init = 1'b1;
                n_cnt           = '0;
                n_state         = fpd_pkg::ST_CORD_RUN;
            end
            fpd_pkg::ST_CORD_RUN: begin
                o_cmd.cord_step = 1'b1;
                if (r_cnt == fpd_pkg::CNT_W'(fpd_pkg::CORDIC_STEPS - 1)) begin
                    n_state = fpd_pkg::ST_RAW_FIN;
                end else begin
                    n_cnt = r_cnt + fpd_pkg::CNT_W'(1);
                end
            end
            fpd_pkg::ST_RAW_FIN: begin
                o_cmd.raw_fin = 1'b1;
                o_cmd.acc_clr = 1'b1;
                n_cnt         = '0;
                n_state       = fpd_pkg::ST_MAC_PH;
            end
            fpd_pkg::ST_MAC_PH: begin
                o_cmd.mac_issue = (r_cnt < ph_taps);
                o_cmd.mac_sel   = 1'b1;
                if (r_cnt == ph_taps + fpd_pkg::CNT_W'(1)) begin
                    n_state = fpd_pkg::ST_OUT;
                end else begin
                    n_cnt = r_cnt + fpd_pkg::CNT_W'(1);
                end
            end
            fpd_pkg::ST_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = fpd_pkg::ST_IDLE;
                end
            end
            default: n_state = fpd_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

/* hdl/fpd_datapath.sv */
`default_nettype none
module fpd_datapath (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  fpd_pkg::t_cmd        i_cmd,
    output fpd_pkg::t_sts        o_sts,
    input  wire  signed [15:0]   i_i_sample,
    input  wire  signed [15:0]   i_q_sample,
    input  wire  [7:0]           i_coef_index,
    input  wire  signed [17:0]   i_coef_value,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic signed [15:0]   o_raw_phase,
    output logic signed [15:0]   o_smoothed_phase
);

    localparam int AW2 = fpd_pkg::CNT_W + 2;
    localparam int AW  = fpd_pkg::ADDR_W;
    localparam int CW  = fpd_pkg::CW;
    localparam int ACW = fpd_pkg::ACC_W;

    logic signed [15:0] r_i_mem   [fpd_pkg::MAX_TAPS];
    logic signed [15:0] r_q_mem   [fpd_pkg::MAX_TAPS];
    logic signed [15:0] r_ph_mem  [fpd_pkg::MAX_TAPS];
    logic signed [17:0] r_iq_coef [fpd_pkg::MAX_TAPS];
    logic signed [17:0] r_ph_coef [fpd_pkg::MAX_TAPS];

    logic [AW-1:0]             r_wptr;
    logic [fpd_pkg::CNT_W-1:0] r_fill;
    logic [AW2-1:0]            addr_sum;
    logic [AW2-1:0]            addr_wrap;
    logic [AW-1:0]             rd_addr;
    logic [AW-1:0]             tap_addr;
    logic [AW-1:0]             coef_addr;
    logic                      coef_ok;

    logic signed [17:0] r_rd_ci, r_rd_cp;
    logic signed [15:0] r_rd_i, r_rd_q, r_rd_p;
    logic               r_v1, r_v2, r_sel1;
    logic signed [33:0] r_prod_a, r_prod_b;
    logic signed [ACW-1:0] r_acc_a, r_acc_b;

    logic signed [15:0] r_ci, r_cq, r_pi, r_pq;
    logic signed [31:0] r_m_ii, r_m_qq, r_m_qi, r_m_iq;
    logic signed [32:0] r_re, r_im;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [CW-1:0] xs, ys;
    logic [31:0]          r_z;
    logic [31:0]          z_rnd;
    logic                 r_zero;
    logic signed [15:0]   raw;
    logic [4:0]           step;
    logic                 r_ovalid;

    assign addr_sum  = AW2'(r_wptr) + AW2'(fpd_pkg::MAX_TAPS) - AW2'(i_cmd.k);
    assign addr_wrap = (addr_sum >= AW2'(fpd_pkg::MAX_TAPS))
                     ? addr_sum - AW2'(fpd_pkg::MAX_TAPS) : addr_sum;
    assign rd_addr   = addr_wrap[AW-1:0];
    // coefficients are indexed by tap, samples by age
    assign tap_addr  = AW'(i_cmd.k);
    assign coef_addr = AW'(i_coef_index);
    assign coef_ok   = int'(i_coef_index) < fpd_pkg::MAX_TAPS;

    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_wr_iq && coef_ok) begin
            r_iq_coef[coef_addr] <= i_coef_value;
        end
        if (i_cmd.coef_wr_ph && coef_ok) begin
            r_ph_coef[coef_addr] <= i_coef_value;
        end
        if (i_cmd.push) begin
            r_i_mem[r_wptr] <= i_i_sample;
            r_q_mem[r_wptr] <= i_q_sample;
        end
        if (i_cmd.raw_fin) begin
            r_ph_mem[r_wptr] <= raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_issue) begin
            r_rd_ci <= r_iq_coef[tap_addr];
            r_rd_cp <= r_ph_coef[tap_addr];
            r_rd_i  <= r_i_mem[rd_addr];
            r_rd_q  <= r_q_mem[rd_addr];
            r_rd_p  <= r_ph_mem[rd_addr];
        end
    end

    // fill count stands in for the zeroed delay lines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr   <= '0;
            r_fill   <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_ovalid <= 1'b0;
            r_pi     <= '0;
            r_pq     <= '0;
        end else begin
            if (i_cmd.push && (r_fill < fpd_pkg::CNT_W'(fpd_pkg::MAX_TAPS))) begin
                r_fill <= r_fill + fpd_pkg::CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_wptr <= (r_wptr == AW'(fpd_pkg::MAX_TAPS - 1)) ? '0 : r_wptr + AW'(1);
            end
            r_v1 <= i_cmd.mac_issue && (i_cmd.k < r_fill);
            r_v2 <= r_v1;
            if (i_cmd.cplx_mul) begin
                r_pi <= r_ci;
                r_pq <= r_cq;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel1   <= i_cmd.mac_sel;
        r_prod_a <= r_sel1 ? r_rd_cp * r_rd_p : r_rd_ci * r_rd_i;
        r_prod_b <= r_rd_ci * r_rd_q;
        if (i_cmd.acc_clr) begin
            r_acc_a <= '0;
            r_acc_b <= '0;
        end else if (r_v2) begin
            r_acc_a <= r_acc_a + ACW'(r_prod_a);
            r_acc_b <= r_acc_b + ACW'(r_prod_b);
        end
    end

    assign step  = i_cmd.k[4:0];
    assign xs    = r_x >>> step;
    assign ys    = r_y >>> step;
    assign z_rnd = r_z + 32'h0000_8000;
    assign raw   = r_zero ? 16'sd0 : signed'(z_rnd[31:16]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.iq_fin) begin
            r_ci <= fpd_pkg::round_sat(r_acc_a);
            r_cq <= fpd_pkg::round_sat(r_acc_b);
        end
        if (i_cmd.cplx_mul) begin
            r_m_ii <= r_pi * r_ci;
            r_m_qq <= r_pq * r_cq;
            r_m_qi <= r_pq * r_ci;
            r_m_iq <= r_pi * r_cq;
        end
        if (i_cmd.cplx_add) begin
            r_re <= 33'(r_m_ii) + 33'(r_m_qq);
            r_im <= 33'(r_m_qi) - 33'(r_m_iq);
        end
        if (i_cmd.cord_init) begin
            r_zero <= (r_re == '0) && (r_im == '0);
            // fold the left half plane by a quarter turn
            if (r_re < 0) begin
                if (r_im >= 0) begin
                    r_x <= CW'(r_im);
                    r_y <= -CW'(r_re);
                    r_z <= 32'h4000_0000;
                end else begin
                    r_x <= -CW'(r_im);
                    r_y <= CW'(r_re);
                    r_z <= 32'hC000_0000;
                end
            end else begin
                r_x <= CW'(r_re);
                r_y <= CW'(r_im);
                r_z <= '0;
            end
        end else if (i_cmd.cord_step) begin
            if (r_y > 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + fpd_pkg::atan_lut(step);
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - fpd_pkg::atan_lut(step);
            end
        end
        if (i_cmd.out_load) begin
            o_raw_phase      <= raw;
            o_smoothed_phase <= fpd_pkg::round_sat(r_acc_a);
        end
    end

    assign o_valid        = r_ovalid;
    assign o_sts.out_busy = r_ovalid && !i_ready;

endmodule
`default_nettype wire

/* hdl/fsk_phase_discriminator.sv */
// FSK phase discriminator: I/Q pulse-shaping FIR, delay-conjugate multiply,
// CORDIC angle, then a phase smoothing FIR.
// Input stream: tuser = action (0 sample, 1 load I/Q tap, 2 load phase tap,
// 3 ignored); tdata carries the sample pair and the tap index/value.
// Load transfers produce nothing and leave the block idle. A sample transfer
// produces exactly one output transfer.
// Per sample, the multiply-accumulate shared by both filters walks each
// delay line memory one tap per cycle, with one CORDIC iteration per cycle
// between the I/Q filter and the phase filter.
// The raw and smoothed phases are loaded into the output register together.
// tready is high only while idle; the result sits in an output register, so
// a new transfer is taken while it waits. If the receiver stalls the block
// finishes the next sample and then holds until the output register frees.
// Config port: i_cfg_we writes register i_cfg_idx (0 iq taps, 1 phase
// taps); write only while idle.
// Reset (synchronous, active low) empties the delay lines, clears the
// previous filtered sample and sets tap counts to 65 and 129. Coefficient
// memories are not cleared and must be loaded before use.
`default_nettype none
module fsk_phase_discriminator (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // i_sample[15:0], q_sample[31:16],
                                        // coef_index[39:32], coef_value[57:40]
    input  wire  [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // raw_phase[15:0], smoothed_phase[31:16]
    input  wire         i_cfg_we,
    input  wire  [0:0]  i_cfg_idx,
    input  wire  [7:0]  i_cfg_data
);

    fpd_pkg::t_cmd      cmd;
    fpd_pkg::t_sts      sts;
    logic signed [15:0] raw_phase;
    logic signed [15:0] smoothed_phase;

    fpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_action   (s_axis_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    fpd_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_i_sample       (s_axis_tdata[15:0]),
        .i_q_sample       (s_axis_tdata[31:16]),
        .i_coef_index     (s_axis_tdata[39:32]),
        .i_coef_value     (s_axis_tdata[57:40]),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_raw_phase      (raw_phase),
        .o_smoothed_phase (smoothed_phase)
    );

    assign m_axis_tdata = {smoothed_phase, raw_phase};

endmodule
`default_nettype wire

/* hdl/fpd_checker.sv */
`default_nettype none
`include "fsk_phase_discriminator_assert.svh"
module fpd_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire [1:0]  s_axis_tuser,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready
);

    `FPD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output dropped while stalled")
    `FPD_ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")
    `FPD_ASSERT(a_sample_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser == fpd_pkg::ACT_SAMPLE |=> !s_axis_tready, "sample transfer did not start work")
    `FPD_ASSERT(a_load_silent, s_axis_tvalid && s_axis_tready && s_axis_tuser != fpd_pkg::ACT_SAMPLE && !m_axis_tvalid |=> !m_axis_tvalid, "load transfer produced output")

endmodule

bind fsk_phase_discriminator fpd_checker u_fpd_checker (.*);
`default_nettype wire
